// ----- hdl/erc_pkg.sv -----
// Shared types and codes for the elevator request controller.
// Used by erc_cell and elevator_request_controller; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erc_pkg;

  localparam int FLOOR_W         = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [FLOOR_W-1:0] TOP_FLOOR = 4'd9;

  localparam logic [1:0] FN_TICK   = 2'd0;
  localparam logic [1:0] FN_SUMMON = 2'd1;
  localparam logic [1:0] FN_SELECT = 2'd2;

  localparam logic [3:0] ST_INVALID    = 4'd0;
  localparam logic [3:0] ST_DUPLICATE  = 4'd1;
  localparam logic [3:0] ST_ACCEPTED   = 4'd2;
  localparam logic [3:0] ST_FULL       = 4'd3;
  localparam logic [3:0] ST_DEST_SET   = 4'd4;
  localparam logic [3:0] ST_NO_REQUEST = 4'd5;
  localparam logic [3:0] ST_LEAVING    = 4'd6;
  localparam logic [3:0] ST_WAITING    = 4'd7;
  localparam logic [3:0] ST_UP         = 4'd8;
  localparam logic [3:0] ST_DOWN       = 4'd9;
  localparam logic [3:0] ST_ARRIVED    = 4'd10;
  localparam logic [3:0] ST_IDLE       = 4'd11;
  localparam logic [3:0] ST_UNUSED     = 4'd12;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic [FLOOR_W-1:0] summon;
    logic [FLOOR_W-1:0] dest;
    logic               has_dest;
  } entry_t;

  typedef struct packed {
    logic               active;
    logic               select;
    logic [FLOOR_W-1:0] floor;
    logic               found;
  } token_t;

endpackage

`default_nettype wire

// ----- hdl/elevator_request_controller.sv -----
// Top level of the single-car elevator request controller: car state, timing
// and a row of erc_cell queue slots walked by a scan token. Uses erc_pkg, erc_cell.
//
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | func, floor
// out     | output    | out_valid / out_stall  | status, current_floor, direction,
//         |           |                        | waiting, elapsed_ticks, queue_count
// cfg     | input     | cfg_we                 | cfg_data (dwell_ticks)
//
// Tick, unused func and out-of-range floors: result registered in the cycle after accept.
// Summon and select: result once the scan token has passed through every cell of the row.
// One transaction is in work at a time; in_stall is high until it is done.
// rst is synchronous: queue empty, car at ground, idle, dwell_ticks 3.
// A stalled result holds in the output register; a new transaction is taken
// in the cycle the held one leaves.
`timescale 1ns / 1ps
`default_nettype none

module elevator_request_controller #(
  parameter int QUEUE_DEPTH = erc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  func,
  input  wire logic [erc_pkg::FLOOR_W-1:0] floor,
  input  wire logic                        cfg_we,
  input  wire logic [7:0]                  cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [3:0]                       status,
  output logic [erc_pkg::FLOOR_W-1:0]      current_floor,
  output logic [1:0]                       direction,
  output logic                             waiting,
  output logic [31:0]                      elapsed_ticks,
  output logic [4:0]                       queue_count
);
  import erc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [FLOOR_W-1:0] car, car_next;
  logic [1:0]         dir, dir_next;
  logic               dwell_active, dwell_active_next;
  logic [7:0]         dwell_count, dwell_count_next;
  logic [31:0]        ticks, ticks_next;
  logic [7:0]         dwell_ticks;

  logic               accept;
  logic               in_range;
  logic               scan_start;
  logic               done;
  logic               result_load;
  logic [3:0]         res_status;
  logic               shift_en;
  logic               push_en;
  logic [7:0]         dwell_inc;
  logic [FLOOR_W-1:0] target;
  entry_t             push_data;
  entry_t             head;

  token_t token_chain [QUEUE_DEPTH+1];
  entry_t entries     [QUEUE_DEPTH];

  assign accept     = in_valid && !in_stall;
  assign in_range   = floor <= TOP_FLOOR;
  assign scan_start = accept && in_range && ((func == FN_SUMMON) || (func == FN_SELECT));
  assign done       = (state == S_SCAN) && token_chain[QUEUE_DEPTH].active;
  assign in_stall   = (state != S_IDLE) || (out_valid && out_stall);
  assign head       = entries[0];
  assign dwell_inc  = dwell_count + 8'd1;
  assign target     = head.has_dest ? head.dest : head.summon;

  assign push_data.summon   = token_chain[QUEUE_DEPTH].floor;
  assign push_data.dest     = '0;
  assign push_data.has_dest = 1'b0;

  always_comb begin
    token_chain[0].active = scan_start;
    token_chain[0].select = func == FN_SELECT;
    token_chain[0].floor  = floor;
    token_chain[0].found  = 1'b0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      entry_t shift_src;
      if (gi == QUEUE_DEPTH - 1) begin : g_last
        assign shift_src = '0;
      end else begin : g_mid
        assign shift_src = entries[gi+1];
      end
      erc_cell #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .INDEX       (gi)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .count     (count),
        .car_floor (car),
        .shift_en  (shift_en),
        .shift_in  (shift_src),
        .push_en   (push_en),
        .push_data (push_data),
        .token_in  (token_chain[gi]),
        .token_out (token_chain[gi+1]),
        .entry     (entries[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next        = state;
    count_next        = count;
    car_next          = car;
    dir_next          = dir;
    dwell_active_next = dwell_active;
    dwell_count_next  = dwell_count;
    ticks_next        = ticks;
    result_load       = 1'b0;
    res_status        = ST_UNUSED;
    shift_en          = 1'b0;
    push_en           = 1'b0;

    if (scan_start) begin
      state_next = S_SCAN;
    end else if (accept) begin
      result_load = 1'b1;
      unique case (func)
        FN_TICK: begin
          ticks_next = ticks + 32'd1;
          if (dwell_active) begin
            if (dwell_inc >= dwell_ticks) begin
              dwell_active_next = 1'b0;
              dwell_count_next  = '0;
              res_status        = ST_LEAVING;
            end else begin
              dwell_count_next = dwell_inc;
              res_status       = ST_WAITING;
            end
          end else if (count != '0) begin
            if (car < target) begin
              dir_next   = DIR_UP;
              car_next   = car + FLOOR_W'(1);
              res_status = ST_UP;
            end else if (car > target) begin
              dir_next   = DIR_DOWN;
              car_next   = car - FLOOR_W'(1);
              res_status = ST_DOWN;
            end else begin
              dir_next          = DIR_IDLE;
              dwell_active_next = 1'b1;
              shift_en          = 1'b1;
              count_next        = count - CW'(1);
              res_status        = ST_ARRIVED;
            end
          end else begin
            dir_next   = DIR_IDLE;
            res_status = ST_IDLE;
          end
        end
        FN_SUMMON, FN_SELECT: res_status = ST_INVALID;
        default: res_status = ST_UNUSED;
      endcase
    end else if (done) begin
      state_next  = S_IDLE;
      result_load = 1'b1;
      if (token_chain[QUEUE_DEPTH].select) begin
        res_status = token_chain[QUEUE_DEPTH].found ? ST_DEST_SET : ST_NO_REQUEST;
      end else if (token_chain[QUEUE_DEPTH].found) begin
        res_status = ST_DUPLICATE;
      end else if (count == CW'(QUEUE_DEPTH)) begin
        res_status = ST_FULL;
      end else begin
        push_en    = 1'b1;
        count_next = count + CW'(1);
        res_status = ST_ACCEPTED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      car          <= '0;
      dir          <= DIR_IDLE;
      dwell_active <= 1'b0;
      dwell_count  <= '0;
      ticks        <= '0;
      dwell_ticks  <= 8'd3;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      car          <= car_next;
      dir          <= dir_next;
      dwell_active <= dwell_active_next;
      dwell_count  <= dwell_count_next;
      ticks        <= ticks_next;
      if (cfg_we) begin
        dwell_ticks <= cfg_data;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      status        <= res_status;
      current_floor <= car_next;
      direction     <= dir_next;
      waiting       <= dwell_active_next;
      elapsed_ticks <= ticks_next;
      queue_count   <= 5'(count_next);
    end
  end

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> in_stall)
    else $error("transaction taken during a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_dwell_idle: assert property (@(posedge clk) disable iff (rst)
    dwell_active |-> (dir == DIR_IDLE))
    else $error("motor running during dwell");

  a_scan_holds_state: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) && !done |=> $stable(count) && $stable(car))
    else $error("queue or car changed during a scan");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_load |-> !(out_valid && out_stall))
    else $error("result overwrites a held transaction");

endmodule

`default_nettype wire

// ----- hdl/erc_cell.sv -----
// One queue slot of the request row: holds an entry, shifts on pop,
// and checks the scan token as it passes to the next slot. Uses erc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erc_cell #(
  parameter int QUEUE_DEPTH = erc_pkg::QUEUE_DEPTH_DEF,
  parameter int INDEX       = 0,
  localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [CW-1:0]                  count,
  input  wire logic [erc_pkg::FLOOR_W-1:0]    car_floor,
  input  wire logic                           shift_en,
  input  wire erc_pkg::entry_t                shift_in,
  input  wire logic                           push_en,
  input  wire erc_pkg::entry_t                push_data,
  input  wire erc_pkg::token_t                token_in,
  output erc_pkg::token_t                     token_out,
  output erc_pkg::entry_t                     entry
);
  import erc_pkg::*;

  logic   occupied;
  logic   open_req;
  logic   hit_summon;
  logic   claim;
  token_t token_next;

  assign occupied   = CW'(INDEX) < count;
  assign open_req   = occupied && !entry.has_dest;
  assign hit_summon = token_in.active && !token_in.select && open_req &&
                      (entry.summon == token_in.floor);
  assign claim      = token_in.active && token_in.select && !token_in.found &&
                      open_req && (entry.summon == car_floor);

  always_comb begin
    token_next       = token_in;
    token_next.found = token_in.found || hit_summon || claim;
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry <= shift_in;
    end else if (push_en && (count == CW'(INDEX))) begin
      entry <= push_data;
    end else if (claim) begin
      entry.dest     <= token_in.floor;
      entry.has_dest <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_out.active <= 1'b0;
    end else begin
      token_out <= token_next;
    end
  end

endmodule

`default_nettype wire
